// ===== rtl/core/qmn_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmn_pkg
// Shared widths, stage indexes, queue item type and arithmetic helpers for
// the quaternion multiply and normalize unit.
// ----------------------------------------------------------------------------
package qmn_pkg;

    localparam int LANES       = 4;
    localparam int IN_W        = 16;
    localparam int OUT_W       = 16;
    localparam int PROD_W      = 34;
    localparam int MAG_W       = 33;
    localparam int SQ_W        = 65;
    localparam int T_W         = 31;
    localparam int ROOT_W      = 16;
    localparam int DIV_STEPS   = 31;
    localparam int SQRT_STEPS  = 16;
    localparam int DIV_BASE    = 1;
    localparam int SQRT_BASE   = DIV_BASE + DIV_STEPS;
    localparam int OUT_STAGE   = SQRT_BASE + SQRT_STEPS;
    localparam int STAGES      = OUT_STAGE + 1;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_CNT_W  = 3;
    localparam int Q_ONE       = 16384;

    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        logic [LANES-1:0]  neg;
        mag_t [LANES-1:0]  mag;
        mag_t              na;
        mag_t              nb;
        logic              zero;
    } item_t;

    typedef struct packed {
        logic [LANES-1:0]  neg;
        logic              zero;
    } side_t;

    function automatic logic signed [PROD_W-1:0] sx_prod(input logic signed [31:0] v);
        return {{(PROD_W-32){v[31]}}, v};
    endfunction

    function automatic mag_t zx_sq(input logic signed [31:0] v);
        return {{(MAG_W-32){1'b0}}, v};
    endfunction

    // square of a magnitude of at most 2^32
    function automatic logic [SQ_W-1:0] sq_mag(input mag_t v);
        logic [63:0] pp;
        pp = v[31:0] * v[31:0];
        if (v[32])
            return {1'b1, 64'b0};
        return {1'b0, pp};
    endfunction

    // product of two squared norms, each at most 2^32
    function automatic logic [SQ_W-1:0] norm_prod(input mag_t na, input mag_t nb);
        logic [63:0] pp;
        pp = na[31:0] * nb[31:0];
        if (na[32])
            return {nb, 32'b0};
        if (nb[32])
            return {na, 32'b0};
        return {1'b0, pp};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/qmn_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmn_front
// Takes requests, forms the Hamilton product and both squared norms, flags
// zero length and hands a compact item to the queue.
// ----------------------------------------------------------------------------
module qmn_front
    import qmn_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic signed [IN_W-1:0] a_x,
    input  wire logic signed [IN_W-1:0] a_y,
    input  wire logic signed [IN_W-1:0] a_z,
    input  wire logic signed [IN_W-1:0] a_w,
    input  wire logic signed [IN_W-1:0] b_x,
    input  wire logic signed [IN_W-1:0] b_y,
    input  wire logic signed [IN_W-1:0] b_z,
    input  wire logic signed [IN_W-1:0] b_w,
    output item_t                       item,
    output logic                        item_valid,
    input  wire logic                   item_ready
);

    logic signed [PROD_W-1:0] p [LANES];
    logic signed [PROD_W-1:0] p_abs;
    item_t                    item_next;
    item_t                    item_reg;
    logic                     valid_reg;
    logic                     valid_next;
    logic                     accept;

    always_comb
    begin
        p[0] = sx_prod(a_w * b_x) + sx_prod(a_x * b_w) + sx_prod(a_y * b_z)
             - sx_prod(a_z * b_y);
        p[1] = sx_prod(a_w * b_y) - sx_prod(a_x * b_z) + sx_prod(a_y * b_w)
             + sx_prod(a_z * b_x);
        p[2] = sx_prod(a_w * b_z) + sx_prod(a_x * b_y) - sx_prod(a_y * b_x)
             + sx_prod(a_z * b_w);
        p[3] = sx_prod(a_w * b_w) - sx_prod(a_x * b_x) - sx_prod(a_y * b_y)
             - sx_prod(a_z * b_z);
        item_next.na = zx_sq(a_x * a_x) + zx_sq(a_y * a_y) + zx_sq(a_z * a_z)
                     + zx_sq(a_w * a_w);
        item_next.nb = zx_sq(b_x * b_x) + zx_sq(b_y * b_y) + zx_sq(b_z * b_z)
                     + zx_sq(b_w * b_w);
        item_next.zero = (item_next.na == '0) || (item_next.nb == '0);
        p_abs = '0;
        for (int l = 0; l < LANES; l++)
        begin
            p_abs = p[l][PROD_W-1] ? -p[l] : p[l];
            item_next.neg[l] = p[l][PROD_W-1];
            item_next.mag[l] = p_abs[MAG_W-1:0];
        end
    end

    assign full       = valid_reg && !item_ready;
    assign accept     = push && !full;
    assign valid_next = accept || (valid_reg && !item_ready);
    assign item       = item_reg;
    assign item_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

endmodule
`default_nettype wire

// ===== rtl/core/qmn_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmn_fifo
// Short queue between the front and the back so that each side stalls on
// its own.
// ----------------------------------------------------------------------------
module qmn_fifo
    import qmn_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire item_t wr_item,
    input  wire logic  wr_valid,
    output logic       wr_ready,
    output item_t      rd_item,
    output logic       rd_valid,
    input  wire logic  rd_ready
);

    item_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  do_wr;
    logic                  do_rd;

    assign wr_ready = count_reg != FIFO_CNT_W'(FIFO_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ===== rtl/core/qmn_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmn_back
// Normalizing pipeline: squares, a one-bit-per-stage divider giving
// floor(2^30 m^2 / S), a one-bit-per-stage square root, then rounding and
// sign. The last stage is the result register.
// ----------------------------------------------------------------------------
module qmn_back
    import qmn_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire item_t in_item,
    input  wire logic  in_valid,
    output logic       in_ready,
    output logic [OUT_W-1:0] out_x,
    output logic [OUT_W-1:0] out_y,
    output logic [OUT_W-1:0] out_z,
    output logic [OUT_W-1:0] out_w,
    output logic       zero_length,
    output logic       empty,
    input  wire logic  pop
);

    logic [STAGES-1:0]  valid_reg;
    logic [STAGES-1:0]  valid_next;
    side_t              side_reg  [STAGES];
    side_t              side_next [STAGES];
    logic [SQ_W-1:0]    den_reg   [DIV_STEPS+1];
    logic [SQ_W-1:0]    den_next  [DIV_STEPS+1];
    logic [SQ_W-1:0]    rem_reg   [DIV_STEPS+1][LANES];
    logic [SQ_W-1:0]    rem_next  [DIV_STEPS+1][LANES];
    logic [T_W-1:0]     quo_reg   [1:DIV_STEPS][LANES];
    logic [T_W-1:0]     quo_next  [1:DIV_STEPS][LANES];
    logic [T_W-1:0]     srem_reg  [SQRT_STEPS][LANES];
    logic [T_W-1:0]     srem_next [SQRT_STEPS][LANES];
    logic [ROOT_W-1:0]  root_reg  [SQRT_STEPS][LANES];
    logic [ROOT_W-1:0]  root_next [SQRT_STEPS][LANES];
    logic [OUT_W-1:0]   out_reg   [LANES];
    logic [OUT_W-1:0]   out_next  [LANES];
    logic               adv;

    logic [SQ_W:0]      sh;
    logic [SQ_W:0]      diff;
    logic [T_W-1:0]     q_prev;
    logic [T_W-1:0]     s_rem;
    logic [ROOT_W-1:0]  s_root;
    logic [T_W:0]       trial;
    logic [T_W:0]       s_diff;
    logic [ROOT_W:0]    rnd;

    assign adv      = !valid_reg[OUT_STAGE] || pop;
    assign in_ready = adv;

    always_comb
    begin
        sh     = '0;
        diff   = '0;
        q_prev = '0;
        s_rem  = '0;
        s_root = '0;
        trial  = '0;
        s_diff = '0;
        rnd    = '0;

        // squares
        valid_next[0]     = in_valid;
        side_next[0].neg  = in_item.neg;
        side_next[0].zero = in_item.zero;
        den_next[0]       = norm_prod(in_item.na, in_item.nb);
        for (int l = 0; l < LANES; l++)
            rem_next[0][l] = sq_mag(in_item.mag[l]);

        for (int s = 1; s < STAGES; s++)
        begin
            valid_next[s] = valid_reg[s-1];
            side_next[s]  = side_reg[s-1];
        end

        // restoring division
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            den_next[k] = den_reg[k-1];
            for (int l = 0; l < LANES; l++)
            begin
                if (k == 1)
                begin
                    sh     = {1'b0, rem_reg[0][l]};
                    q_prev = '0;
                end
                else
                begin
                    sh     = {rem_reg[k-1][l], 1'b0};
                    q_prev = quo_reg[k-1][l];
                end
                diff = sh - {1'b0, den_reg[k-1]};
                if (sh >= {1'b0, den_reg[k-1]})
                begin
                    rem_next[k][l] = diff[SQ_W-1:0];
                    quo_next[k][l] = {q_prev[T_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k][l] = sh[SQ_W-1:0];
                    quo_next[k][l] = {q_prev[T_W-2:0], 1'b0};
                end
            end
        end

        // square root, one root bit per stage
        for (int j = 0; j < SQRT_STEPS; j++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (j == 0)
                begin
                    s_rem  = quo_reg[DIV_STEPS][l];
                    s_root = '0;
                end
                else
                begin
                    s_rem  = srem_reg[j-1][l];
                    s_root = root_reg[j-1][l];
                end
                trial  = ({{(T_W+1-ROOT_W){1'b0}}, s_root} << (SQRT_STEPS - j))
                       + ((T_W+1)'(1) << (2 * (SQRT_STEPS - 1 - j)));
                s_diff = {1'b0, s_rem} - trial;
                if ({1'b0, s_rem} >= trial)
                begin
                    srem_next[j][l] = s_diff[T_W-1:0];
                    root_next[j][l] = s_root | (ROOT_W'(1) << (SQRT_STEPS - 1 - j));
                end
                else
                begin
                    srem_next[j][l] = s_rem;
                    root_next[j][l] = s_root;
                end
            end
        end

        // round to nearest and apply sign
        for (int l = 0; l < LANES; l++)
        begin
            rnd = ({1'b0, root_reg[SQRT_STEPS-1][l]} + (ROOT_W+1)'(1)) >> 1;
            if (side_reg[OUT_STAGE-1].zero)
                out_next[l] = '0;
            else if (side_reg[OUT_STAGE-1].neg[l])
                out_next[l] = -rnd[OUT_W-1:0];
            else
                out_next[l] = rnd[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg  <= side_next;
            den_reg   <= den_next;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            srem_reg  <= srem_next;
            root_reg  <= root_next;
            out_reg   <= out_next;
        end
    end

    assign out_x       = out_reg[0];
    assign out_y       = out_reg[1];
    assign out_z       = out_reg[2];
    assign out_w       = out_reg[3];
    assign zero_length = side_reg[OUT_STAGE].zero;
    assign empty       = !valid_reg[OUT_STAGE];

    a_zero_forces_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && zero_length) |->
        (out_x == '0 && out_y == '0 && out_z == '0 && out_w == '0))
        else $error("zero length result with nonzero component");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |->
        ($signed(out_x) <= Q_ONE && $signed(out_x) >= -Q_ONE &&
         $signed(out_y) <= Q_ONE && $signed(out_y) >= -Q_ONE &&
         $signed(out_z) <= Q_ONE && $signed(out_z) >= -Q_ONE &&
         $signed(out_w) <= Q_ONE && $signed(out_w) >= -Q_ONE))
        else $error("normalized component out of unit range");

    a_stall_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_x) && $stable(zero_length)))
        else $error("result changed while stalled");

endmodule
`default_nettype wire

// ===== rtl/core/quaternion_multiply_normalize_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize_unit
// Hamilton product of two Q1.14 quaternions, normalized to unit length.
// ----------------------------------------------------------------------------
// Takes one request per cycle while full is low and returns one result per
// cycle while pop is held, in request order. A request passes the product
// register, which loads at the edge that takes it, then the queue, the
// squares stage, the bit-per-stage divider, the bit-per-stage square root
// and the rounding stage. The divider and root pipelines make up most of
// the stages; the four-entry queue lets requests keep entering while
// results wait.
// ----------------------------------------------------------------------------
module quaternion_multiply_normalize_unit
    import qmn_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic signed [IN_W-1:0] a_x,
    input  wire logic signed [IN_W-1:0] a_y,
    input  wire logic signed [IN_W-1:0] a_z,
    input  wire logic signed [IN_W-1:0] a_w,
    input  wire logic signed [IN_W-1:0] b_x,
    input  wire logic signed [IN_W-1:0] b_y,
    input  wire logic signed [IN_W-1:0] b_z,
    input  wire logic signed [IN_W-1:0] b_w,
    output logic signed [OUT_W-1:0]     out_x,
    output logic signed [OUT_W-1:0]     out_y,
    output logic signed [OUT_W-1:0]     out_z,
    output logic signed [OUT_W-1:0]     out_w,
    output logic                        zero_length,
    output logic                        empty,
    input  wire logic                   pop
);

    item_t front_item;
    logic  front_valid;
    logic  front_ready;
    item_t back_item;
    logic  back_valid;
    logic  back_ready;

    qmn_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .a_x        (a_x),
        .a_y        (a_y),
        .a_z        (a_z),
        .a_w        (a_w),
        .b_x        (b_x),
        .b_y        (b_y),
        .b_z        (b_z),
        .b_w        (b_w),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    qmn_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_item  (front_item),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_item  (back_item),
        .rd_valid (back_valid),
        .rd_ready (back_ready)
    );

    qmn_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_item     (back_item),
        .in_valid    (back_valid),
        .in_ready    (back_ready),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .out_w       (out_w),
        .zero_length (zero_length),
        .empty       (empty),
        .pop         (pop)
    );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quaternion multiply and normalize unit.
// A table of directed requests runs first, then random pairs. Idle gaps and
// output stalls are random. Typed rows are checked against their table values,
// the rest against an integer predictor that rounds each unit component exactly.
// ----------------------------------------------------------------------------
module tb_top
    import qmn_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 1200;
    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 80;

    typedef logic signed [IN_W-1:0]  comp_t;
    typedef logic signed [OUT_W-1:0] res_t;

    typedef struct {
        comp_t ax, ay, az, aw, bx, by, bz, bw;
    } pair_t;

    typedef struct {
        res_t x, y, z, w;
        logic zero;
    } unit_t;

    typedef struct {
        pair_t req;
        bit    typed;
        unit_t want;
    } row_t;

    logic  clk;
    logic  rst_n;
    logic  push;
    logic  full;
    comp_t a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w;
    res_t  out_x, out_y, out_z, out_w;
    logic  zero_length;
    logic  empty;
    logic  pop;

    unit_t unit_q[$];
    int    errors;
    int    idle_cycles;

    quaternion_multiply_normalize_unit dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
        .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w),
        .zero_length(zero_length), .empty(empty), .pop(pop)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    // nearest q with (2q-1)^2 * s <= 2^30 * m^2, by bisection
    function automatic res_t round_unit(input longint p, input logic [127:0] s);
        logic [127:0] m;
        logic [127:0] d;
        logic [127:0] rhs;
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = 16385;
        m = (p < 0) ? 128'(-p) : 128'(p);
        rhs = (m * m) << 30;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            d = 128'(2 * mid - 1);
            if (d * d * s <= rhs)
                lo = mid;
            else
                hi = mid;
        end
        return (p < 0) ? res_t'(-lo) : res_t'(lo);
    endfunction

    function automatic unit_t unit_product(input pair_t r);
        longint ax, ay, az, aw, bx, by, bz, bw;
        longint px, py, pz, pw;
        logic [127:0] na;
        logic [127:0] nb;
        unit_t u;
        ax = r.ax; ay = r.ay; az = r.az; aw = r.aw;
        bx = r.bx; by = r.by; bz = r.bz; bw = r.bw;
        px = aw * bx + ax * bw + ay * bz - az * by;
        py = aw * by - ax * bz + ay * bw + az * bx;
        pz = aw * bz + ax * by - ay * bx + az * bw;
        pw = aw * bw - ax * bx - ay * by - az * bz;
        na = 128'(ax * ax + ay * ay + az * az + aw * aw);
        nb = 128'(bx * bx + by * by + bz * bz + bw * bw);
        if (na == 0 || nb == 0)
        begin
            u = '{x: '0, y: '0, z: '0, w: '0, zero: 1'b1};
            return u;
        end
        u.x = round_unit(px, na * nb);
        u.y = round_unit(py, na * nb);
        u.z = round_unit(pz, na * nb);
        u.w = round_unit(pw, na * nb);
        u.zero = 1'b0;
        return u;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int draw_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send(input pair_t r, input unit_t want, input bit typed);
        bit ok;
        push <= 1'b1;
        a_x <= r.ax; a_y <= r.ay; a_z <= r.az; a_w <= r.aw;
        b_x <= r.bx; b_y <= r.by; b_z <= r.bz; b_w <= r.bw;
        do
        begin
            @(negedge clk);
            ok = !full;
            @(posedge clk);
        end
        while (!ok);
        unit_q.push_back(typed ? want : unit_product(r));
    endtask

    task automatic pause_sender();
        int n;
        n = draw_pause();
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic comp_t rand_comp(input int mode);
        case (mode)
            0: return comp_t'($urandom);
            1: return comp_t'($urandom_range(0, 64)) - comp_t'(32);
            2: return ($urandom_range(0, 1) != 0) ? comp_t'(-32768) : comp_t'(32767);
            default: return ($urandom_range(0, 3) == 0) ? comp_t'(0) : comp_t'($urandom);
        endcase
    endfunction

    function automatic pair_t rand_pair();
        pair_t r;
        int mode;
        int k;
        mode = $urandom_range(0, 9);
        mode = (mode < 5) ? 0 : (mode < 7) ? 1 : (mode < 8) ? 2 : 3;
        r.ax = rand_comp(mode); r.ay = rand_comp(mode);
        r.az = rand_comp(mode); r.aw = rand_comp(mode);
        r.bx = rand_comp(mode); r.by = rand_comp(mode);
        r.bz = rand_comp(mode); r.bw = rand_comp(mode);
        k = $urandom_range(0, 19);
        if (k == 0)
        begin
            r.ax = '0; r.ay = '0; r.az = '0; r.aw = '0;
        end
        else if (k == 1)
        begin
            r.bx = '0; r.by = '0; r.bz = '0; r.bw = '0;
        end
        return r;
    endfunction

    function automatic row_t mk(input int ax, ay, az, aw, bx, by, bz, bw,
                                input bit typed, input int x, y, z, w, input bit zero);
        row_t t;
        t.req = '{ax: comp_t'(ax), ay: comp_t'(ay), az: comp_t'(az), aw: comp_t'(aw),
                  bx: comp_t'(bx), by: comp_t'(by), bz: comp_t'(bz), bw: comp_t'(bw)};
        t.typed = typed;
        t.want = '{x: res_t'(x), y: res_t'(y), z: res_t'(z), w: res_t'(w), zero: zero};
        return t;
    endfunction

    initial
    begin
        row_t rows[$];
        rst_n = 1'b0;
        push <= 1'b0;
        a_x <= '0; a_y <= '0; a_z <= '0; a_w <= '0;
        b_x <= '0; b_y <= '0; b_z <= '0; b_w <= '0;
        errors = 0;
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1));
        rows.push_back(mk(0, 0, 0, 0, 5, -7, 9, 16384, 1, 0, 0, 0, 0, 1));
        rows.push_back(mk(-32768, 32767, 1, -1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1));
        rows.push_back(mk(0, 0, 0, 16384, 0, 0, 0, 16384, 1, 0, 0, 0, 16384, 0));
        rows.push_back(mk(16384, 0, 0, 0, 0, 16384, 0, 0, 1, 0, 0, 16384, 0, 0));
        rows.push_back(mk(0, 16384, 0, 0, 16384, 0, 0, 0, 1, 0, 0, -16384, 0, 0));
        rows.push_back(mk(1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, -16384, 0));
        rows.push_back(mk(0, 0, 0, -32768, 0, 0, 0, -32768, 1, 0, 0, 0, 16384, 0));
        rows.push_back(mk(0, 0, 0, -32768, 0, 0, 0, 32767, 1, 0, 0, 0, -16384, 0));
        rows.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                          0, 0, 0, 0, 0, 0));
        rows.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                          0, 0, 0, 0, 0, 0));
        rows.push_back(mk(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767,
                          0, 0, 0, 0, 0, 0));
        rows.push_back(mk(1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(1, 0, 0, 1, 0, 1, 0, 1, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(11585, 0, 0, 11585, 0, 0, 11585, 11585, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(-1, 2, -3, 4, 32767, -32768, 1, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(21845, -10923, 4096, -1, 3, 0, -16384, 8192, 0, 0, 0, 0, 0, 0));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
        begin
            send(rows[i].req, rows[i].want, rows[i].typed);
            if (i % 5 == 4)
                pause_sender();
        end
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            send(rand_pair(), '{x: '0, y: '0, z: '0, w: '0, zero: 1'b0}, 1'b0);
            pause_sender();
        end
        push <= 1'b0;
        while (unit_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int stall;
        bit got;
        unit_t seen;
        unit_t want;
        stall = 0;
        pop <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (stall == 0)
                stall = ($urandom_range(0, 3) == 0) ? draw_pause() : 0;
            if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
                pop <= 1'b1;
            @(negedge clk);
            got = pop && !empty && rst_n;
            seen = '{x: out_x, y: out_y, z: out_z, w: out_w, zero: zero_length};
            @(posedge clk);
            if (got)
            begin
                if (unit_q.size() == 0)
                    report("unexpected result", seen.w, 0);
                else
                begin
                    want = unit_q.pop_front();
                    if (seen.x !== want.x)
                        report("out_x", seen.x, want.x);
                    if (seen.y !== want.y)
                        report("out_y", seen.y, want.y);
                    if (seen.z !== want.z)
                        report("out_z", seen.z, want.z);
                    if (seen.w !== want.w)
                        report("out_w", seen.w, want.w);
                    if (seen.zero !== want.zero)
                        report("zero_length", seen.zero, want.zero);
                end
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

// ===== quaternion_multiply_normalize_unit.f =====
rtl/core/qmn_pkg.sv
rtl/core/qmn_front.sv
rtl/core/qmn_fifo.sv
rtl/core/qmn_back.sv
rtl/core/quaternion_multiply_normalize_unit.sv
tb/tb_top.sv
